// ----- design/linear_quotient_hash_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// linear quotient hash table: assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef LINEAR_QUOTIENT_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_QUOTIENT_HASH_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define LQH_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LQH_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LQH_ASSERT(name, clk, rst, prop, msg)
`define LQH_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ----- design/lqh_pkg.sv -----
// ----------------------------------------------------------------------------
// lqh_pkg
// types and fixed constants of the linear quotient hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lqh_pkg;

   // width of the table size register and of divisor and remainder
   localparam int CSR_BITS      = 6;
   // width of the probe count field
   localparam int PROBE_BITS    = 6;
   // result item: outcome, found, probes, one byte
   localparam int RSP_DATA_BITS = 8;
   // table size after reset
   localparam logic [CSR_BITS-1:0] SLOT_LIMIT_RESET = 6'd31;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } lqh_cmd_type;

   localparam logic OUTCOME_STORED  = 1'b0;
   localparam logic OUTCOME_DROPPED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HOME,
      ST_STEP,
      ST_INSERT,
      ST_READ,
      ST_COMPARE,
      ST_FINISH
   } lqh_state_type;

endpackage

// ----- design/linear_quotient_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_quotient_hash_table_core
// open-addressed hash table with linear quotient probing
// ----------------------------------------------------------------------------
// Each request item carries a command in req_tuser (insert or look up) and a
// key in req_tdata. The home slot is key mod S and the probe step is
// (key div S) mod S, where S is the table size register clamped to 1..slots
// in use. An insert stores the key in the first free slot of the probe cycle
// and reports dropped when the cycle comes back home; a lookup skips empty
// slots and reports found plus the 1-based probe position, or 0 if absent.
// One item is in work at a time. Both values come from one shared bit-serial
// divider run twice, then the probe cycle is walked slot by slot: an insert
// checks a slot in ST_INSERT, a lookup reads the key ram in ST_READ and then
// compares in ST_COMPARE. ST_FINISH hands the result to the output register
// and waits there while the previous result still waits unclaimed; the
// sequencer then returns to idle before the next item is taken. A new request
// is taken while the previous result still waits in the output register.
// Valid bits are flip-flops cleared by reset, so the table is usable as soon
// as reset ends; the table size may be written only while no item is in
// work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_quotient_hash_table_core_defines.svh"

module linear_quotient_hash_table_core
   import lqh_pkg::*;
#(
   parameter int MAX_SLOTS = 32,
   parameter int KEY_BITS  = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((KEY_BITS + 7) / 8) * 8-1:0] req_tdata,  // key, zero padding
   input  logic                                req_tuser,  // cmd
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,  // outcome, found, probes
   // table size register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_BITS-1:0]                 csr_data    // slot_limit
);

   // the size register tops out at 63, so no slot beyond that is ever used
   localparam int MAX_SIZE   = (1 << CSR_BITS) - 1;
   localparam int USED_SLOTS = (MAX_SLOTS < MAX_SIZE) ? MAX_SLOTS : MAX_SIZE;
   localparam int IDX_BITS   = $clog2(USED_SLOTS);

   // control state
   lqh_state_type           state_ff, state_in;
   logic [CSR_BITS-1:0]     slot_limit_ff, slot_limit_in;
   logic [USED_SLOTS-1:0]   valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // working registers of the item in flight
   lqh_cmd_type             cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [IDX_BITS-1:0]     home_ff, home_in;
   logic [IDX_BITS-1:0]     step_ff, step_in;
   logic [IDX_BITS-1:0]     pos_ff, pos_in;
   logic [PROBE_BITS-1:0]   count_ff, count_in;
   logic                    outcome_ff, outcome_in;
   logic                    found_ff, found_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // effective size and next probe position
   logic [CSR_BITS-1:0]     size_eff;
   logic [CSR_BITS:0]       pos_sum;
   logic [IDX_BITS-1:0]     pos_next;

   // divider hookup
   logic                    div_start;
   logic [KEY_BITS-1:0]     div_dividend;
   logic                    div_done;
   logic [KEY_BITS-1:0]     div_quotient;
   logic [CSR_BITS-1:0]     div_remainder;

   // key ram hookup
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [KEY_BITS-1:0]     ram_rd_data;

   logic                    req_accept;
   logic                    rsp_free;

   // size 0 acts as 1, anything past the slots in use is clamped
   always_comb begin
      if (slot_limit_ff == '0) begin
         size_eff = CSR_BITS'(1);
      end else if (slot_limit_ff > CSR_BITS'(USED_SLOTS)) begin
         size_eff = CSR_BITS'(USED_SLOTS);
      end else begin
         size_eff = slot_limit_ff;
      end
   end

   // pos and step are both below the size, so one subtract wraps the sum
   always_comb begin
      pos_sum  = (CSR_BITS + 1)'(pos_ff) + (CSR_BITS + 1)'(step_ff);
      pos_next = (pos_sum >= (CSR_BITS + 1)'(size_eff))
               ? IDX_BITS'(pos_sum - (CSR_BITS + 1)'(size_eff))
               : IDX_BITS'(pos_sum);
   end

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // config writes are taken at once
   assign csr_ready     = 1'b1;
   assign slot_limit_in = (csr_valid && csr_ready) ? csr_data : slot_limit_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      outcome_in   = outcome_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = req_tdata[KEY_BITS-1:0];
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               // first pass: key / size gives the home slot
               cmd_in    = lqh_cmd_type'(req_tuser);
               key_in    = req_tdata[KEY_BITS-1:0];
               div_start = 1'b1;
               state_in  = ST_HOME;
            end
         end
         ST_HOME: begin
            div_dividend = div_quotient;
            if (div_done) begin
               // second pass: quotient mod size gives the step
               home_in   = IDX_BITS'(div_remainder);
               div_start = 1'b1;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            div_dividend = div_quotient;
            if (div_done) begin
               step_in    = IDX_BITS'(div_remainder);
               pos_in     = home_ff;
               count_in   = '0;
               outcome_in = OUTCOME_STORED;
               found_in   = 1'b0;
               state_in   = (cmd_ff == CMD_INSERT) ? ST_INSERT : ST_READ;
            end
         end
         ST_INSERT: begin
            if (!valid_ff[pos_ff]) begin
               ram_wr_en          = 1'b1;
               valid_in[pos_ff]   = 1'b1;
               outcome_in         = OUTCOME_STORED;
               state_in           = ST_FINISH;
            end else if (pos_next == home_ff) begin
               // cycle closed without a free slot, zero step included
               outcome_in = OUTCOME_DROPPED;
               state_in   = ST_FINISH;
            end else begin
               pos_in = pos_next;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            count_in  = count_ff + PROBE_BITS'(1);
            state_in  = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (valid_ff[pos_ff] && (ram_rd_data == key_ff)) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else if (pos_next == home_ff) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               pos_in   = pos_next;
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (rsp_free) begin
               if (cmd_ff == CMD_INSERT) begin
                  rsp_data_in = {PROBE_BITS'(0), 1'b0, outcome_ff};
               end else begin
                  rsp_data_in = {found_ff ? count_ff : PROBE_BITS'(0), found_ff,
                                 OUTCOME_STORED};
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_limit_ff <= SLOT_LIMIT_RESET;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_limit_ff <= slot_limit_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      home_ff     <= home_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      count_ff    <= count_in;
      outcome_ff  <= outcome_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared divider for home slot and step
   lqh_div #(
      .DATA_BITS (KEY_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (size_eff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // slot keys, a read result counts only where the valid bit is set
   lqh_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (USED_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   `LQH_ASSERT(a_accept_starts_div, clock, reset, req_accept |=> (state_ff == ST_HOME), "accepted item did not start the divider")
   `LQH_ASSERT(a_pos_in_range, clock, reset, ((state_ff == ST_INSERT) || (state_ff == ST_READ) || (state_ff == ST_COMPARE)) |-> ((CSR_BITS + 1)'(pos_ff) < (CSR_BITS + 1)'(size_eff)), "probe position past table size")
   `LQH_ASSERT(a_write_free_slot, clock, reset, ram_wr_en |-> !valid_ff[pos_ff], "insert overwrote an occupied slot")
   `LQH_ASSERT(a_count_bound, clock, reset, (state_ff == ST_COMPARE) |-> (count_ff <= PROBE_BITS'(size_eff)), "probe count past table size")
   `LQH_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "result shown without finishing an item")

endmodule

// ----- design/lqh_ram.sv -----
// ----------------------------------------------------------------------------
// lqh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lqh_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lqh_div.sv -----
// ----------------------------------------------------------------------------
// lqh_div
// restoring divider by a small divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_quotient_hash_table_core_defines.svh"

module lqh_div
   import lqh_pkg::*;
#(
   parameter int DATA_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DATA_BITS-1:0] dividend,
   input  logic [CSR_BITS-1:0]  divisor,
   output logic                 done,
   output logic [DATA_BITS-1:0] quotient,
   output logic [CSR_BITS-1:0]  remainder
);

   localparam int CNT_BITS = $clog2(DATA_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DATA_BITS-1:0] quo_ff, quo_in;
   logic [CSR_BITS-1:0]  rem_ff, rem_in;
   logic [CSR_BITS-1:0]  den_ff, den_in;

   logic [CSR_BITS:0]    trial;
   logic [CSR_BITS:0]    diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DATA_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // dividend shifts out at the top while quotient bits shift in
         quo_in = {quo_ff[DATA_BITS-2:0], fits};
         rem_in = fits ? diff[CSR_BITS-1:0] : trial[CSR_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `LQH_ASSERT(a_div_start_idle, clock, reset, start |-> !busy_ff, "divider started while busy")
   `LQH_ASSERT(a_div_nonzero, clock, reset, (start && !busy_ff) |-> (divisor != '0), "divide by zero")
   `LQH_ASSERT(a_div_rem_range, clock, reset, done_ff |-> (rem_ff < den_ff), "remainder not below divisor")

endmodule
